>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the segment detector.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge outside reset
`define EGSD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be seen outside reset
`define EGSD_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

>>> rtl/egsd_pkg.sv
// ----------------------------------------------------------------------------
// egsd_pkg
// Types and constants shared by the energy gated segment detector.
// ----------------------------------------------------------------------------
package egsd_pkg;

   localparam int INDEX_BITS_DEF  = 32;
   localparam int QUEUE_DEPTH_DEF = 4;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_ENERGY_THRESHOLD = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HANG_SAMPLES     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BACK_PAD         = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRONT_PAD        = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_LENGTH       = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_LENGTH    = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_STREAM_LENGTH    = 3'd6;

   localparam logic [30:0] ENERGY_THRESHOLD_RST = 31'd10737;
   localparam logic [15:0] HANG_SAMPLES_RST     = 16'd441;
   localparam logic [15:0] BACK_PAD_RST         = 16'd88;
   localparam logic [15:0] FRONT_PAD_RST        = 16'd88;
   localparam logic [19:0] MIN_LENGTH_RST       = 20'd2205;
   localparam logic [15:0] WINDOW_LENGTH_RST    = 16'd1024;
   localparam logic [31:0] STREAM_LENGTH_RST    = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [30:0] energy_threshold;
      logic [15:0] hang_samples;
      logic [15:0] back_pad;
      logic [15:0] front_pad;
      logic [19:0] min_length;
      logic [15:0] window_length;
      logic [31:0] stream_length;
   } cfg_type;

   typedef enum logic [1:0] {
      EVT_NONE,
      EVT_CLOSE,
      EVT_FLUSH
   } evt_kind_type;

   typedef struct packed {
      evt_kind_type kind;
      logic         clr;
   } evt_ctl_type;

endpackage

>>> rtl/energy_gated_segment_detector_top.sv
// ----------------------------------------------------------------------------
// energy_gated_segment_detector_top
// Energy gated segment detector with hangover, padding and window extension.
// ----------------------------------------------------------------------------
// Takes one signed 16-bit sample per cycle while the queue has room, and
// reports each detected segment as start index, end index (one past the last
// sample) and a running number from 1. The classifier updates the segment
// state in the cycle a sample is transferred and posts close or stream-end
// events into a QUEUE_DEPTH-entry queue; the segment calculator takes one
// event per cycle through three arithmetic stages and an output register,
// from which each segment shows on rsp_valid. A stalled result holds the
// calculator, and input is stalled only once the queue is full.
// Configuration writes take effect at once and belong in idle periods.
// ----------------------------------------------------------------------------
module energy_gated_segment_detector_top #(
   parameter int INDEX_BITS  = egsd_pkg::INDEX_BITS_DEF,
   parameter int QUEUE_DEPTH = egsd_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic signed [15:0]              req_sample,
   input  logic                            req_last,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [31:0]                     rsp_segment_start,
   output logic [31:0]                     rsp_segment_end,
   output logic [31:0]                     rsp_segment_number,
   input  logic                            csr_write_enable,
   input  logic [egsd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [egsd_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import egsd_pkg::*;

   localparam int QW = $bits(evt_ctl_type) + 2 * INDEX_BITS;

   cfg_type               cfg_ff, cfg_in;

   logic                  push;
   evt_ctl_type           push_ctl;
   logic [INDEX_BITS-1:0] push_index;
   logic [INDEX_BITS-1:0] push_start;
   logic                  q_full;
   logic                  pop;
   logic                  q_valid;
   logic [QW-1:0]         q_data;
   evt_ctl_type           q_ctl;
   logic [INDEX_BITS-1:0] q_index;
   logic [INDEX_BITS-1:0] q_start;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_ENERGY_THRESHOLD: cfg_in.energy_threshold = csr_write_data[30:0];
            CSR_HANG_SAMPLES:     cfg_in.hang_samples     = csr_write_data[15:0];
            CSR_BACK_PAD:         cfg_in.back_pad         = csr_write_data[15:0];
            CSR_FRONT_PAD:        cfg_in.front_pad        = csr_write_data[15:0];
            CSR_MIN_LENGTH:       cfg_in.min_length       = csr_write_data[19:0];
            CSR_WINDOW_LENGTH:    cfg_in.window_length    = csr_write_data[15:0];
            CSR_STREAM_LENGTH:    cfg_in.stream_length    = csr_write_data[31:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.energy_threshold <= ENERGY_THRESHOLD_RST;
         cfg_ff.hang_samples     <= HANG_SAMPLES_RST;
         cfg_ff.back_pad         <= BACK_PAD_RST;
         cfg_ff.front_pad        <= FRONT_PAD_RST;
         cfg_ff.min_length       <= MIN_LENGTH_RST;
         cfg_ff.window_length    <= WINDOW_LENGTH_RST;
         cfg_ff.stream_length    <= STREAM_LENGTH_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   egsd_front #(
      .INDEX_BITS (INDEX_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_sample (req_sample),
      .req_last   (req_last),
      .q_full     (q_full),
      .push       (push),
      .push_ctl   (push_ctl),
      .push_index (push_index),
      .push_start (push_start)
   );

   egsd_queue #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  ({push_ctl, push_index, push_start}),
      .full       (q_full),
      .pop        (pop),
      .head_valid (q_valid),
      .head_data  (q_data)
   );

   assign q_ctl   = q_data[QW-1 -: $bits(evt_ctl_type)];
   assign q_index = q_data[2*INDEX_BITS-1 -: INDEX_BITS];
   assign q_start = q_data[INDEX_BITS-1:0];

   egsd_back #(
      .INDEX_BITS (INDEX_BITS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .q_valid            (q_valid),
      .q_ctl              (q_ctl),
      .q_index            (q_index),
      .q_start            (q_start),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_segment_start  (rsp_segment_start),
      .rsp_segment_end    (rsp_segment_end),
      .rsp_segment_number (rsp_segment_number)
   );

endmodule

>>> rtl/egsd_front.sv
// ----------------------------------------------------------------------------
// egsd_front
// Classifies each sample as loud or silent, tracks the open segment and
// posts close, flush and end-of-stream events to the event queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module egsd_front #(
   parameter int INDEX_BITS = egsd_pkg::INDEX_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  egsd_pkg::cfg_type       cfg,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [15:0]      req_sample,
   input  logic                    req_last,
   input  logic                    q_full,
   output logic                    push,
   output egsd_pkg::evt_ctl_type   push_ctl,
   output logic [INDEX_BITS-1:0]   push_index,
   output logic [INDEX_BITS-1:0]   push_start
);
   import egsd_pkg::*;

   logic [INDEX_BITS-1:0] index_ff, index_in;
   logic [INDEX_BITS-1:0] open_start_ff, open_start_in;
   logic                  open_ff, open_in;
   logic [31:0]           silent_ff, silent_in;

   logic signed [31:0]    square;
   logic                  accept;
   logic                  loud;
   logic [31:0]           silent_inc;
   logic                  close;
   logic                  open_after;
   logic [INDEX_BITS-1:0] start_after;

   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;

   assign square     = req_sample * req_sample;
   assign loud       = square[30:0] > cfg.energy_threshold;
   assign silent_inc = (silent_ff == '1) ? silent_ff : silent_ff + 32'd1;
   assign close      = !loud && open_ff && (silent_inc >= 32'(cfg.hang_samples));
   assign open_after = loud || (open_ff && !close);
   assign start_after = (loud && !open_ff) ? index_ff : open_start_ff;

   always_comb begin
      index_in      = index_ff;
      open_in       = open_ff;
      open_start_in = open_start_ff;
      silent_in     = silent_ff;
      if (accept) begin
         index_in = index_ff + INDEX_BITS'(1);
         if (loud) begin
            if (!open_ff) begin
               open_in       = 1'b1;
               open_start_in = index_ff;
               silent_in     = '0;
            end
         end else if (open_ff) begin
            silent_in = close ? '0 : silent_inc;
            open_in   = !close;
         end
         if (req_last) begin
            index_in      = '0;
            open_in       = 1'b0;
            open_start_in = '0;
            silent_in     = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff      <= '0;
         open_ff       <= 1'b0;
         open_start_ff <= '0;
         silent_ff     <= '0;
      end else begin
         index_ff      <= index_in;
         open_ff       <= open_in;
         open_start_ff <= open_start_in;
         silent_ff     <= silent_in;
      end
   end

   always_comb begin
      push_ctl.clr = req_last;
      if (close) begin
         push_ctl.kind = EVT_CLOSE;
      end else if (req_last && open_after) begin
         push_ctl.kind = EVT_FLUSH;
      end else begin
         push_ctl.kind = EVT_NONE;
      end
   end

   assign push       = accept && (close || req_last);
   assign push_index = index_ff;
   assign push_start = start_after;

   `EGSD_ASSERT(a_front_no_push_full, clock, reset, push |-> !q_full,
      "event posted into a full queue")
   `EGSD_ASSERT(a_front_last_clears, clock, reset,
      (accept && req_last) |=> (index_ff == '0 && !open_ff),
      "stream state not cleared after final sample")

endmodule

>>> rtl/egsd_queue.sv
// ----------------------------------------------------------------------------
// egsd_queue
// Small register FIFO between the classifier and the segment calculator.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module egsd_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = egsd_pkg::QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output logic [WIDTH-1:0] head_data
);
   import egsd_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]  count_ff, count_in;

   assign full       = (count_ff == CNTW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNTW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNTW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   `EGSD_NEVER(a_queue_pop_empty, clock, reset, pop && count_ff == '0,
      "event taken from an empty queue")

endmodule

>>> rtl/egsd_back.sv
// ----------------------------------------------------------------------------
// egsd_back
// Pads, extends and clamps closed segments, handles stream-end flushes and
// numbers the emitted segments through an output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module egsd_back #(
   parameter int INDEX_BITS = egsd_pkg::INDEX_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  egsd_pkg::cfg_type       cfg,
   input  logic                    q_valid,
   input  egsd_pkg::evt_ctl_type   q_ctl,
   input  logic [INDEX_BITS-1:0]   q_index,
   input  logic [INDEX_BITS-1:0]   q_start,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [31:0]             rsp_segment_start,
   output logic [31:0]             rsp_segment_end,
   output logic [31:0]             rsp_segment_number
);
   import egsd_pkg::*;

   localparam int CW = ((INDEX_BITS > 32) ? INDEX_BITS : 32) + 3;

   logic adv;

   logic signed [CW-1:0] idx_ext, st_ext, bp_ext, hang_ext, fp_ext;
   logic signed [CW-1:0] ml_ext, win_ext, sl_ext;
   logic signed [CW-1:0] end0, stp_raw, stp, fld;

   logic                 s1_vld_ff, s1_vld_in;
   evt_ctl_type          s1_ctl_ff, s1_ctl_in;
   logic signed [CW-1:0] s1_end0_ff, s1_end0_in;
   logic signed [CW-1:0] s1_st_ff, s1_st_in;
   logic signed [CW-1:0] s1_stp_ff, s1_stp_in;
   logic signed [CW-1:0] s1_fld_ff, s1_fld_in;

   logic signed [CW-1:0] d_close, d_win, end1;
   logic                 keep;

   logic                 s2_vld_ff, s2_vld_in;
   logic                 s2_emit_ff, s2_emit_in;
   logic                 s2_flush_ff, s2_flush_in;
   logic                 s2_clr_ff, s2_clr_in;
   logic [31:0]          s2_start_ff, s2_start_in;
   logic signed [CW-1:0] s2_end1_ff, s2_end1_in;

   logic                 s3_vld_ff, s3_vld_in;
   logic                 s3_emit_ff, s3_emit_in;
   logic                 s3_flush_ff, s3_flush_in;
   logic                 s3_clr_ff, s3_clr_in;
   logic [31:0]          s3_start_ff, s3_start_in;
   logic signed [CW-1:0] s3_end2_ff, s3_end2_in;

   logic signed [CW-1:0] end_clamp;
   logic [31:0]          end_final;
   logic                 load_rsp;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [31:0]          rsp_start_ff, rsp_start_in;
   logic [31:0]          rsp_end_ff, rsp_end_in;
   logic [31:0]          rsp_number_ff, rsp_number_in;
   logic [31:0]          cnt_ff, cnt_in;

   assign adv = !rsp_valid_ff || !rsp_stall;
   assign pop = adv && q_valid;

   // entry: raw end, padded start, flush span
   assign idx_ext  = CW'(q_index);
   assign st_ext   = CW'(q_start);
   assign bp_ext   = CW'(cfg.back_pad);
   assign hang_ext = CW'(cfg.hang_samples);
   assign fp_ext   = CW'(cfg.front_pad);
   assign ml_ext   = CW'(cfg.min_length);
   assign win_ext  = CW'(cfg.window_length);
   assign sl_ext   = CW'(cfg.stream_length);

   assign end0    = idx_ext + CW'(1) + bp_ext - hang_ext;
   assign stp_raw = st_ext - fp_ext;
   assign stp     = stp_raw[CW-1] ? '0 : stp_raw;
   assign fld     = sl_ext - st_ext;

   assign s1_vld_in  = adv ? q_valid : s1_vld_ff;
   assign s1_ctl_in  = adv ? q_ctl   : s1_ctl_ff;
   assign s1_end0_in = adv ? end0    : s1_end0_ff;
   assign s1_st_in   = adv ? st_ext  : s1_st_ff;
   assign s1_stp_in  = adv ? stp     : s1_stp_ff;
   assign s1_fld_in  = adv ? fld     : s1_fld_ff;

   // length check and window extension
   assign d_close = s1_end0_ff - s1_st_ff;
   assign d_win   = s1_end0_ff - s1_stp_ff;
   assign end1    = (d_win < win_ext) ? s1_stp_ff + win_ext + CW'(1) : s1_end0_ff;

   always_comb begin
      case (s1_ctl_ff.kind)
         EVT_CLOSE: keep = d_close > ml_ext;
         EVT_FLUSH: keep = s1_fld_ff >= win_ext;
         default:   keep = 1'b0;
      endcase
   end

   assign s2_vld_in   = adv ? s1_vld_ff : s2_vld_ff;
   assign s2_emit_in  = adv ? keep : s2_emit_ff;
   assign s2_flush_in = adv ? (s1_ctl_ff.kind == EVT_FLUSH) : s2_flush_ff;
   assign s2_clr_in   = adv ? s1_ctl_ff.clr : s2_clr_ff;
   assign s2_start_in = adv ? ((s1_ctl_ff.kind == EVT_CLOSE) ? s1_stp_ff[31:0]
                                                             : s1_st_ff[31:0])
                            : s2_start_ff;
   assign s2_end1_in  = adv ? end1 : s2_end1_ff;

   // back padding
   assign s3_vld_in   = adv ? s2_vld_ff   : s3_vld_ff;
   assign s3_emit_in  = adv ? s2_emit_ff  : s3_emit_ff;
   assign s3_flush_in = adv ? s2_flush_ff : s3_flush_ff;
   assign s3_clr_in   = adv ? s2_clr_ff   : s3_clr_ff;
   assign s3_start_in = adv ? s2_start_ff : s3_start_ff;
   assign s3_end2_in  = adv ? (s2_end1_ff + bp_ext) : s3_end2_ff;

   // clamp, number and hold for transfer
   assign end_clamp = (s3_end2_ff > sl_ext) ? sl_ext : s3_end2_ff;
   assign end_final = s3_flush_ff ? cfg.stream_length : end_clamp[31:0];
   assign load_rsp  = adv && s3_vld_ff && s3_emit_ff;

   assign rsp_valid_in  = adv ? (s3_vld_ff && s3_emit_ff) : rsp_valid_ff;
   assign rsp_start_in  = load_rsp ? s3_start_ff : rsp_start_ff;
   assign rsp_end_in    = load_rsp ? end_final : rsp_end_ff;
   assign rsp_number_in = load_rsp ? cnt_ff + 32'd1 : rsp_number_ff;

   always_comb begin
      cnt_in = cnt_ff;
      if (adv && s3_vld_ff) begin
         if (s3_clr_ff) begin
            cnt_in = '0;
         end else if (s3_emit_ff) begin
            cnt_in = cnt_ff + 32'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         s3_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         s1_vld_ff    <= s1_vld_in;
         s2_vld_ff    <= s2_vld_in;
         s3_vld_ff    <= s3_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ctl_ff     <= s1_ctl_in;
      s1_end0_ff    <= s1_end0_in;
      s1_st_ff      <= s1_st_in;
      s1_stp_ff     <= s1_stp_in;
      s1_fld_ff     <= s1_fld_in;
      s2_emit_ff    <= s2_emit_in;
      s2_flush_ff   <= s2_flush_in;
      s2_clr_ff     <= s2_clr_in;
      s2_start_ff   <= s2_start_in;
      s2_end1_ff    <= s2_end1_in;
      s3_emit_ff    <= s3_emit_in;
      s3_flush_ff   <= s3_flush_in;
      s3_clr_ff     <= s3_clr_in;
      s3_start_ff   <= s3_start_in;
      s3_end2_ff    <= s3_end2_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_end_ff    <= rsp_end_in;
      rsp_number_ff <= rsp_number_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_segment_start  = rsp_start_ff;
   assign rsp_segment_end    = rsp_end_ff;
   assign rsp_segment_number = rsp_number_ff;

   `EGSD_ASSERT(a_back_count_clear, clock, reset,
      (adv && s3_vld_ff && s3_clr_ff) |=> (cnt_ff == '0),
      "segment count not cleared at stream end")

endmodule
